// File: rtl/b64lw_pkg.sv
// Shared types, character constants and the base64 symbol map for the
// line-wrapping base64 encoder. No dependencies.
package b64lw_pkg;

	localparam logic [7:0] LF_CHAR  = 8'h0A;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// Groups per line after reset: 18 groups give 72-character lines.
	localparam logic [4:0] GPL_RESET = 5'd18;

	// A group is four symbols, plus a leading line feed when the line is full.
	localparam int unsigned GroupMax = 5;
	localparam int unsigned CntW     = $clog2(GroupMax + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
	} out_word_t;

	// One finished run of characters; chars[0] leaves first.
	typedef struct packed {
		logic [GroupMax-1:0][7:0] chars;
		logic [CntW-1:0]          count;
	} group_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
	function automatic logic [7:0] b64_sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage

// File: rtl/base64_line_wrapping_encoder_core.sv
// Top level of the line-wrapping base64 encoder: byte collector and group
// encoder feeding a character result register. Depends on b64lw_pkg.
//
//   channel  direction  handshake              word
//   cfg      in         cfg_we                 cfg_data (groups per line)
//   in       in         in_valid / in_ready    in_word  (data_byte, end_of_buffer)
//   out      out        out_valid / out_ready  out_word (out_char, last_of_run)
//
// A word is taken only while the result register is empty or is sending the
// last character of its run. A byte that only joins the pending pair gives no
// characters; a byte that completes a group, or ends a buffer, loads four or
// five characters, which leave one per cycle while out_ready is high. Reset
// (arst_n low) clears pending bytes, the line group count and the output, and
// sets the line length to 18 groups. A stall on out_ready holds the current
// character and backs up to in_ready.
module base64_line_wrapping_encoder_core import b64lw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_word_t   in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_word
);

	logic   take;
	logic   emit;
	logic   can_load;
	group_t group;

	// Ready follows the result register alone: a word is taken when the
	// register is empty or is sending its last character.
	assign in_ready = can_load;
	assign take     = in_valid && in_ready;

	b64lw_group_former u_former (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.take     (take),
		.word     (in_word),
		.emit     (emit),
		.group    (group)
	);

	// The run is captured only when the accepted byte actually closes a group.
	b64lw_char_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && emit),
		.group     (group),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// File: rtl/b64lw_group_former.sv
// Byte collector and group encoder: holds the pending bytes, line group
// count and line length register. Depends on b64lw_pkg.
module b64lw_group_former import b64lw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data,
	input  logic       take,
	input  in_word_t   word,
	output logic       emit,
	output group_t     group
);

	logic [15:0] pend_q;
	logic [1:0]  pend_cnt_q;
	logic [4:0]  line_cnt_q;
	logic [4:0]  gpl_q;

	logic        full;
	logic        two;
	logic        lf;
	logic [7:0]  b0, b1, b2;
	logic [7:0]  c0, c1, c2, c3;

	assign full = (pend_cnt_q >= 2'd2);
	assign emit = full || word.end_of_buffer;
	assign lf   = (line_cnt_q == gpl_q);

	always_comb begin
		two = 1'b1;
		if (full) begin
			b0 = pend_q[15:8];
			b1 = pend_q[7:0];
			b2 = word.data_byte;
		end else if (pend_cnt_q == 2'd1) begin
			b0 = pend_q[7:0];
			b1 = word.data_byte;
			b2 = 8'h00;
		end else begin
			b0 = word.data_byte;
			b1 = 8'h00;
			b2 = 8'h00;
			two = 1'b0;
		end
		c0 = b64_sym(b0[7:2]);
		c1 = b64_sym({b0[1:0], b1[7:4]});
		c2 = two  ? b64_sym({b1[3:0], b2[7:6]}) : PAD_CHAR;
		c3 = full ? b64_sym(b2[5:0]) : PAD_CHAR;
		if (lf) begin
			group.chars = {c3, c2, c1, c0, LF_CHAR};
			group.count = CntW'(5);
		end else begin
			group.chars = {PAD_CHAR, c3, c2, c1, c0};
			group.count = CntW'(4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
			line_cnt_q <= '0;
			gpl_q      <= GPL_RESET;
		end else begin
			if (cfg_we) begin
				gpl_q <= cfg_data;
			end
			if (take) begin
				if (emit) begin
					pend_q     <= '0;
					pend_cnt_q <= '0;
					if (full) begin
						line_cnt_q <= (lf ? 5'd0 : line_cnt_q) + 5'd1;
					end else begin
						line_cnt_q <= '0;
					end
				end else if (pend_cnt_q == 2'd1) begin
					pend_q     <= {pend_q[7:0], word.data_byte};
					pend_cnt_q <= 2'd2;
				end else begin
					pend_q     <= {8'h00, word.data_byte};
					pend_cnt_q <= 2'd1;
				end
			end
		end
	end

endmodule

// File: rtl/b64lw_char_queue.sv
// Result register for one run of characters, shifted out one character
// per handshake. Depends on b64lw_pkg.
module b64lw_char_queue import b64lw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  group_t    group,
	output logic      can_load,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic [GroupMax-1:0][7:0] chars_q;
	logic [CntW-1:0]          rem_q;
	logic                     pop;

	assign out_valid            = (rem_q != '0);
	assign pop                  = out_valid && out_ready;
	assign can_load             = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready);
	assign out_word.out_char    = chars_q[0];
	assign out_word.last_of_run = (rem_q == CntW'(1));

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= group.chars;
		end else if (pop) begin
			chars_q <= {8'h00, chars_q[GroupMax-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= group.count;
		end else if (pop) begin
			rem_q <= CntW'(rem_q - CntW'(1));
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CntW'(GroupMax))
		else $error("character count beyond group size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (rem_q == '0 || (rem_q == CntW'(1) && pop)))
		else $error("run loaded over undelivered characters");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !load) |=> (rem_q == CntW'($past(rem_q) - CntW'(1))))
		else $error("character count did not step down on a pop");

	a_load_size: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (rem_q == CntW'(4) || rem_q == CntW'(5)))
		else $error("run loaded with a wrong length");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the line-wrapping base64 encoder core.
// Uses b64lw_pkg for the word types and character constants, and needs only
// the RTL of base64_line_wrapping_encoder_core and its two submodules.
`timescale 1ns / 1ps

// Tracks the bytes the encoder has taken and the characters they must turn
// into, and checks each character that leaves the block against them.
class base64_char_tracker;
	logic [4:0]  limit;
	logic [15:0] held;
	logic [1:0]  held_n;
	logic [4:0]  line_n;
	b64lw_pkg::out_word_t due[$];
	int errors;
	int seen;
	string alphabet;

	function new();
		alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		limit = b64lw_pkg::GPL_RESET;
		held = '0;
		held_n = '0;
		line_n = '0;
		errors = 0;
		seen = 0;
	endfunction

	function void set_limit(logic [4:0] v);
		limit = v;
	endfunction

	function int outstanding();
		return due.size();
	endfunction

	function logic [7:0] symbol(logic [5:0] v);
		return alphabet[int'(v)];
	endfunction

	function void push_char(logic [7:0] c, logic last);
		b64lw_pkg::out_word_t w;
		w.out_char = c;
		w.last_of_run = last;
		due.push_back(w);
	endfunction

	// One group of four characters, led by a line feed when the line is full.
	function void encode_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int nbytes);
		if (line_n == limit) begin
			push_char(b64lw_pkg::LF_CHAR, 1'b0);
			line_n = '0;
		end
		push_char(symbol(b0[7:2]), 1'b0);
		push_char(symbol({b0[1:0], b1[7:4]}), 1'b0);
		push_char(nbytes >= 2 ? symbol({b1[3:0], b2[7:6]}) : b64lw_pkg::PAD_CHAR, 1'b0);
		push_char(nbytes >= 3 ? symbol(b2[5:0]) : b64lw_pkg::PAD_CHAR, 1'b1);
	endfunction

	function void take_byte(logic [7:0] b, logic eob);
		if (held_n == 2'd2) begin
			encode_group(held[15:8], held[7:0], b, 3);
			line_n = line_n + 5'd1;
			held = '0;
			held_n = '0;
		end else if (held_n == 2'd1) begin
			held = {held[7:0], b};
			held_n = 2'd2;
			if (eob) begin
				encode_group(held[15:8], held[7:0], 8'h00, 2);
				line_n = '0;
				held = '0;
				held_n = '0;
			end
		end else begin
			held = {8'h00, b};
			held_n = 2'd1;
			if (eob) begin
				encode_group(b, 8'h00, 8'h00, 1);
				line_n = '0;
				held = '0;
				held_n = '0;
			end
		end
	endfunction

	function void note_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function void match_char(b64lw_pkg::out_word_t got);
		b64lw_pkg::out_word_t want;
		seen++;
		if (due.size() == 0) begin
			note_error($sformatf("char %0d: got %h/%b with nothing due",
				seen, got.out_char, got.last_of_run));
			return;
		end
		want = due.pop_front();
		if (got.out_char !== want.out_char || got.last_of_run !== want.last_of_run)
			note_error($sformatf("char %0d: expected %h/%b, got %h/%b", seen,
				want.out_char, want.last_of_run, got.out_char, got.last_of_run));
	endfunction
endclass

module testbench;
	import b64lw_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic [4:0] cfg_data;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	// When set, neither side inserts gaps, so the block runs at full rate.
	bit quiet;
	int ready_hold;
	base64_char_tracker tracker;

	// Random phases: line limit, number of bytes, and whether buffers are kept
	// to whole triples so the group count runs on across the phase boundary.
	int phase_limit[6] = '{18, 31, 2, 1, 0, 0};
	int phase_bytes[6] = '{54, 84, 21, 6, 6, 6};
	bit phase_whole[6] = '{1, 1, 1, 0, 0, 0};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	base64_line_wrapping_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	// Idle lengths: mostly none, otherwise a random gap drawn from one of two ranges.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// The receiver: ready for one cycle, then possibly stalled for a while.
	// Stalls can land on any character of a run, including the line feed.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold = ready_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			ready_hold = pick_gap();
		end
	end

	// Every word leaving the block is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.match_char(out_word);
	end

	// Offers one byte at a falling edge and holds it until the block takes it.
	// Returns at a falling edge; valid only drops when an idle gap follows, so
	// back-to-back words keep valid high without a glitch.
	task automatic send_byte(input logic [7:0] b, input logic eob);
		int gap;
		in_word.data_byte <= b;
		in_word.end_of_buffer <= eob;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.take_byte(b, eob);
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stops sending and waits until every expected character has left. A byte
	// that only joins the pending pair gives no character, so the task waits on
	// past the drain to let such a byte settle before the register changes.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [4:0] v);
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.set_limit(v);
	endtask

	initial begin
		int len;
		int sent;
		logic eob;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_word = '0;
		out_ready = 1'b0;
		ready_hold = 0;
		quiet = 1'b0;
		tracker = new();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed, at the reset line length: single-byte and two-byte buffers
		// (two pads and one pad) at the byte extremes, full triples of all zeros and
		// all ones, and a buffer that ends on a full triple, which keeps the
		// group count.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b1);

		// A limit of zero: the count is zero only at the start of a line, so
		// the first group of each line gets a line feed in front of it.
		settle();
		write_limit(5'd0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(8'h9A, 1'b1);
		send_byte(8'h01, 1'b1);

		// A limit of one: every group after the first on a line is preceded
		// by a line feed.
		settle();
		write_limit(5'd1);
		repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);

		// Random phases. The first three keep buffers to whole triples so the
		// group count carries on: the reset length of 18 is reached, the count
		// climbs high under 31, and then the limit drops to 2, below the count,
		// so no line feed comes until the count wraps past 31 and climbs again.
		// The last phases use short buffers of any length, and one runs with
		// no idling at all.
		phase_limit[5] = $urandom_range(0, 31);
		for (int p = 0; p < 6; p++) begin
			settle();
			write_limit(5'(phase_limit[p]));
			quiet = (p == 3);
			sent = 0;
			while (sent < phase_bytes[p]) begin
				len = phase_whole[p] ? 3 * $urandom_range(1, 4) : $urandom_range(1, 7);
				for (int i = 0; i < len && sent < phase_bytes[p]; i++) begin
					if (phase_whole[p])
						eob = (i == len - 1) && $urandom_range(0, 1);
					else
						eob = (i == len - 1);
					send_byte(8'($urandom_range(0, 255)), eob);
					sent++;
				end
			end
			quiet = 1'b0;
		end

		// Drain, then give the block a little longer to show any stray word.
		settle();
		repeat (20) @(negedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Run limit: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
rtl/b64lw_pkg.sv
rtl/b64lw_group_former.sv
rtl/b64lw_char_queue.sv
rtl/base64_line_wrapping_encoder_core.sv
tb/testbench.sv
